>>> rtl/km2d_pkg.sv
// ----------------------------------------------------------------------------
// km2d_pkg
// shared types and codes for the 2-d k-means iteration unit
// ----------------------------------------------------------------------------
package km2d_pkg;

    // cluster memory depth and coordinate width, fixed by the port layout
    localparam int MAX_CLUSTERS = 16;
    localparam int COORD_BITS   = 16;

    // request function codes
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_ASSIGN = 2'd1;
    localparam logic [1:0] FUNC_UPDATE = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ASSIGN_RD,
        ST_ASSIGN_SQ,
        ST_ASSIGN_CMP,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_UPD_RD,
        ST_UPD_DIV,
        ST_UPD_WR,
        ST_OUT
    } t_state;

endpackage

>>> rtl/km2d_divider.sv
// ----------------------------------------------------------------------------
// km2d_divider
// restoring divider, one quotient bit per cycle, unsigned
// ----------------------------------------------------------------------------
module km2d_divider
    import km2d_pkg::*;
#(
    parameter int NUM_BITS = 44,
    parameter int DEN_BITS = 21
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_quot;
    logic [DEN_BITS:0]   r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DEN_BITS:0]   n_shift;

    assign n_shift = {r_rem[DEN_BITS-1:0], r_quot[NUM_BITS-1]};

    // one shift-subtract step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(NUM_BITS);
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (n_shift >= {1'b0, r_den}) begin
                    r_rem  <= n_shift - {1'b0, r_den};
                    r_quot <= {r_quot[NUM_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= n_shift;
                    r_quot <= {r_quot[NUM_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> rtl/kmeans_2d_iteration_unit.sv
// ----------------------------------------------------------------------------
// kmeans_2d_iteration_unit
// one lloyd k-means iteration on 2-d points, state held in two memories
// ----------------------------------------------------------------------------
// s_axis carries requests: tdata = {point_y, point_x, entry_index}, tuser = func.
// m_axis returns one result per request: tdata = {moved, nearest_id}.
// i_cfg_we/i_cfg_data write active_clusters (0 acts as 1, above max as max).
// One request is worked on at a time; s_axis_tready is low while it works.
// Work per request: load writes the centroid memory when it is accepted.
// assign: each of the N active centroids takes a memory read, a squaring stage
// and a compare, then a read-modify-write of the accumulator memory follows.
// update: each of the MAX_CLUSTERS entries takes a memory read, then the serial
// divider (x and y divided in turn), then a write stage.
// Reset clears centroids and accumulators by valid bits in flip-flops, so no
// clearing pass is needed; active_clusters resets to 4.
// A result sits in an output register until m_axis_tready; meanwhile one more
// request is taken, and its result holds the sequencer until the register
// is free, so s_axis_tready stays low.
// ----------------------------------------------------------------------------
module kmeans_2d_iteration_unit
    import km2d_pkg::*;
#(
    parameter int FRAC_BITS       = 8,
    parameter int MAX_POINTS_LOG2 = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] entry_index, [19:4] point_x, [35:20] point_y, [39:36] zero
    input  logic [39:0] s_axis_tdata,
    // [1:0] func
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] nearest_id, [4] moved, [7:5] zero
    output logic [7:0]  m_axis_tdata
);
    localparam int IDX_BITS = $clog2(MAX_CLUSTERS);
    localparam int CW       = COORD_BITS + FRAC_BITS;
    localparam int SW       = COORD_BITS + MAX_POINTS_LOG2;
    localparam int CNTW     = MAX_POINTS_LOG2 + 1;
    localparam int DW       = CW + 1;
    localparam int SQW      = 2 * DW;
    localparam int NUMW     = SW + FRAC_BITS;
    localparam int ACW      = 2 * SW + CNTW;
    localparam int NW       = $clog2(MAX_CLUSTERS + 1);

    // centroid memory {y,x} and accumulator memory {cnt,sy,sx}
    logic [2*CW-1:0] r_cmem [MAX_CLUSTERS];
    logic [ACW-1:0]  r_amem [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0] r_cval, r_aval;
    logic [2*CW-1:0] r_crd;
    logic [ACW-1:0]  r_ard;
    logic            r_crd_v, r_ard_v;

    t_state r_state, n_state;
    logic [4:0]          r_active;
    logic [1:0]          r_func;
    logic [3:0]          r_idx;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic [IDX_BITS-1:0] r_k, r_best;
    logic [SQW:0]        r_bdist;
    logic                r_moved;
    logic                r_ovalid;
    logic [3:0]          r_oid;
    logic                r_omoved;
    logic                r_divy;
    logic                r_dgo;
    logic [CW-1:0]       r_nx;
    logic [NW-1:0]       n_active;

    // clamp of the active cluster count
    always_comb begin
        if (r_active == 5'd0) n_active = NW'(1);
        else if (32'(r_active) > MAX_CLUSTERS) n_active = NW'(MAX_CLUSTERS);
        else n_active = NW'(r_active);
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_active <= 5'd4;
        else if (i_cfg_we) r_active <= i_cfg_data;
    end

    // centroid read data, invalid entries read as zero
    logic signed [CW-1:0] w_cx, w_cy;
    assign w_cx = r_crd_v ? r_crd[CW-1:0] : '0;
    assign w_cy = r_crd_v ? r_crd[2*CW-1:CW] : '0;
    logic signed [SW-1:0] w_sx, w_sy;
    logic [CNTW-1:0]      w_cnt;
    assign w_sx  = r_ard_v ? r_ard[SW-1:0] : '0;
    assign w_sy  = r_ard_v ? r_ard[2*SW-1:SW] : '0;
    assign w_cnt = r_ard_v ? r_ard[ACW-1:2*SW] : '0;

    // distance: squares of differences
    logic signed [DW-1:0] w_dx, w_dy;
    logic [DW-1:0]        w_mx, w_my;
    logic [SQW:0]         w_dist;
    assign w_dx = DW'($signed({r_px, {FRAC_BITS{1'b0}}})) - DW'(w_cx);
    assign w_dy = DW'($signed({r_py, {FRAC_BITS{1'b0}}})) - DW'(w_cy);
    assign w_mx = w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
    assign w_my = w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
    logic [SQW-1:0] r_sqx, r_sqy;
    assign w_dist = {1'b0, r_sqx} + {1'b0, r_sqy};

    // divider for update
    logic                w_dstart, w_ddone;
    logic [NUMW-1:0]     w_num, w_quot;
    logic signed [SW-1:0] w_sel;
    logic [SW-1:0]       w_smag;
    assign w_sel  = r_divy ? w_sy : w_sx;
    assign w_smag = w_sel[SW-1] ? SW'(-w_sel) : SW'(w_sel);
    assign w_num  = {w_smag, {FRAC_BITS{1'b0}}};
    logic [CW-1:0] w_q;
    assign w_q = w_sel[SW-1] ? CW'(-w_quot) : CW'(w_quot);

    km2d_divider #(.NUM_BITS(NUMW), .DEN_BITS(CNTW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_dstart),
        .i_num  (w_num),
        .i_den  (w_cnt),
        .o_done (w_ddone),
        .o_quot (w_quot)
    );

    logic w_accept;
    logic w_out_free;
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_dstart = r_dgo;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) begin
                if (s_axis_tuser == FUNC_ASSIGN) n_state = ST_ASSIGN_RD;
                else if (s_axis_tuser == FUNC_UPDATE) n_state = ST_UPD_RD;
                else n_state = ST_OUT;
            end
            ST_ASSIGN_RD:  n_state = ST_ASSIGN_SQ;
            ST_ASSIGN_SQ:  n_state = ST_ASSIGN_CMP;
            ST_ASSIGN_CMP: n_state = (NW'(r_k) + NW'(1) >= n_active)
                                     ? ST_ACC_RD : ST_ASSIGN_RD;
            ST_ACC_RD:     n_state = ST_ACC_WR;
            ST_ACC_WR:     n_state = ST_OUT;
            ST_UPD_RD:     n_state = ST_UPD_DIV;
            ST_UPD_DIV:    if (w_ddone && r_divy) n_state = ST_UPD_WR;
            ST_UPD_WR:     n_state = (32'(r_k) + 1 >= MAX_CLUSTERS) ? ST_OUT : ST_UPD_RD;
            ST_OUT:        n_state = w_out_free ? ST_IDLE : ST_OUT;
            default:       n_state = ST_IDLE;
        endcase
    end

    logic w_upd_act;
    assign w_upd_act = (NW'(r_k) < n_active) && (w_cnt != '0);

    // divider start pulses: x after the memory read, y after the x quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dgo <= 1'b0;
        else r_dgo <= (r_state == ST_UPD_RD) ||
                      ((r_state == ST_UPD_DIV) && w_ddone && !r_divy);
    end

    // sequencer, memory access and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_cval   <= '0;
            r_aval   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && w_out_free) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (w_accept) begin
                    r_func  <= s_axis_tuser;
                    r_idx   <= s_axis_tdata[3:0];
                    r_px    <= s_axis_tdata[4 +: COORD_BITS];
                    r_py    <= s_axis_tdata[20 +: COORD_BITS];
                    r_k     <= '0;
                    r_best  <= '0;
                    r_moved <= 1'b0;
                    if (s_axis_tuser == FUNC_LOAD && 32'(s_axis_tdata[3:0]) < MAX_CLUSTERS) begin
                        r_cmem[s_axis_tdata[IDX_BITS-1:0]] <=
                            {s_axis_tdata[20 +: COORD_BITS], {FRAC_BITS{1'b0}},
                             s_axis_tdata[4 +: COORD_BITS], {FRAC_BITS{1'b0}}};
                        r_cval[s_axis_tdata[IDX_BITS-1:0]] <= 1'b1;
                    end
                end
                ST_ASSIGN_RD, ST_UPD_RD: begin
                    r_crd   <= r_cmem[r_k];
                    r_crd_v <= r_cval[r_k];
                    r_ard   <= r_amem[r_k];
                    r_ard_v <= r_aval[r_k];
                    r_divy  <= 1'b0;
                end
                ST_ASSIGN_CMP: begin
                    if (r_k == '0 || w_dist < r_bdist) begin
                        r_bdist <= w_dist;
                        r_best  <= r_k;
                    end
                    r_k <= r_k + 1'b1;
                end
                ST_ACC_RD: begin
                    r_ard   <= r_amem[r_best];
                    r_ard_v <= r_aval[r_best];
                end
                ST_ACC_WR: begin
                    if (w_cnt < CNTW'(1 << MAX_POINTS_LOG2)) begin
                        r_amem[r_best] <= {w_cnt + 1'b1, w_sy + SW'(r_py), w_sx + SW'(r_px)};
                        r_aval[r_best] <= 1'b1;
                    end
                end
                ST_UPD_DIV: if (w_ddone) begin
                    if (!r_divy) begin
                        r_nx   <= w_q;
                        r_divy <= 1'b1;
                    end
                end
                ST_UPD_WR: begin
                    if (w_upd_act && ({w_q, r_nx} != {w_cy, w_cx})) begin
                        r_moved <= 1'b1;
                        r_cmem[r_k] <= {w_q, r_nx};
                        r_cval[r_k] <= 1'b1;
                    end
                    r_aval[r_k] <= 1'b0;
                    r_k <= r_k + 1'b1;
                end
                ST_OUT: if (w_out_free) begin
                    r_omoved <= (r_func == FUNC_UPDATE) && r_moved;
                    if (r_func == FUNC_LOAD) r_oid <= r_idx;
                    else if (r_func == FUNC_ASSIGN) r_oid <= 4'(r_best);
                    else r_oid <= 4'd0;
                end
                default: ;
            endcase
        end
    end

    // registered squares after the centroid read
    always_ff @(posedge i_clk) begin
        r_sqx <= w_mx * w_mx;
        r_sqy <= w_my * w_my;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, r_omoved, r_oid};
endmodule

>>> dv/kmeans_2d_iteration_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_2d_iteration_unit_tb
// self-checking bench: load, assign and update requests with random gaps,
// results predicted by a behavioral copy of the iteration and compared in order
// ----------------------------------------------------------------------------
module kmeans_2d_iteration_unit_tb
    import km2d_pkg::*;
;

    localparam int NCL = 16;
    localparam int FRAC = 8;
    localparam longint FULL_COUNT = 64'd1 << 20;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    kmeans_2d_iteration_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // predicted cluster state
    logic [4:0]     cl_active = 5'd4;
    longint         cen_x [NCL];
    longint         cen_y [NCL];
    longint         acc_x [NCL];
    longint         acc_y [NCL];
    longint         members [NCL];
    logic [4:0]     expected_results [$];
    int             error_count = 0;
    longint         cycle_count = 0;
    int             hold_off = 0;
    bit             stall_test = 0;

    // ---------------- prediction ----------------
    function automatic longint mean_q8(longint s, longint c);
        longint q;
        q = ((s < 0 ? -s : s) <<< FRAC) / c;
        return s < 0 ? -q : q;
    endfunction

    function automatic logic [4:0] predict_request(logic [1:0] fn, logic [3:0] idx,
                                                   logic signed [15:0] px,
                                                   logic signed [15:0] py);
        int n, best;
        longint fx, fy, dx, dy;
        logic [127:0] d, bd;
        logic moved_any;
        longint nx, ny;
        n = (cl_active < 1) ? 1 : (cl_active > NCL ? NCL : cl_active);
        fx = longint'(px) <<< FRAC;
        fy = longint'(py) <<< FRAC;
        case (fn)
            FUNC_LOAD: begin
                cen_x[idx] = fx;
                cen_y[idx] = fy;
                return {1'b0, idx};
            end
            FUNC_ASSIGN: begin
                best = 0;
                bd = '1;
                for (int k = 0; k < n; k++) begin
                    dx = fx - cen_x[k];
                    dy = fy - cen_y[k];
                    d = 128'(dx * dx) + 128'(dy * dy);
                    if (d < bd) begin
                        bd = d;
                        best = k;
                    end
                end
                if (members[best] < FULL_COUNT) begin
                    acc_x[best] += px;
                    acc_y[best] += py;
                    members[best]++;
                end
                return {1'b0, 4'(best)};
            end
            FUNC_UPDATE: begin
                moved_any = 1'b0;
                for (int k = 0; k < n; k++) begin
                    if (members[k] != 0) begin
                        nx = mean_q8(acc_x[k], members[k]);
                        ny = mean_q8(acc_y[k], members[k]);
                        if (nx != cen_x[k] || ny != cen_y[k]) begin
                            moved_any = 1'b1;
                            cen_x[k] = nx;
                            cen_y[k] = ny;
                        end
                    end
                end
                for (int k = 0; k < NCL; k++) begin
                    acc_x[k] = 0;
                    acc_y[k] = 0;
                    members[k] = 0;
                end
                return {moved_any, 4'd0};
            end
            default: return 5'd0;
        endcase
    endfunction

    // ---------------- driving ----------------
    task automatic random_gap();
        int r, g;
        r = $urandom_range(0, 99);
        if (r < 40) g = 0;
        else if (r < 95) g = $urandom_range(1, 3);
        else g = $urandom_range(10, 40);
        if (g > 0) s_axis_tvalid <= 1'b0;
        repeat (g) @(posedge i_clk);
    endtask

    // tvalid stays high after the handshake until a gap or wait_idle drops it
    task automatic send_request(logic [1:0] fn, logic [3:0] idx,
                                logic [15:0] px, logic [15:0] py, bit gaps = 1);
        if (gaps) random_gap();
        expected_results.push_back(predict_request(fn, idx, px, py));
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {4'd0, py, px, idx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_active(logic [4:0] v);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        cl_active = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // receiver backpressure: random, or one long hold when requested
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (stall_test && hold_off < 300) begin
            hold_off <= hold_off + 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (!stall_test) hold_off <= 0;
            m_axis_tready <= ($urandom_range(0, 99) < 70);
        end
    end

    // result check
    always @(posedge i_clk) begin
        logic [4:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, -1);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[3:0] !== want[3:0])
                    report_mismatch("nearest_id", m_axis_tdata[3:0], want[3:0]);
                if (m_axis_tdata[4] !== want[4])
                    report_mismatch("moved", m_axis_tdata[4], want[4]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------- tests ----------------
    function automatic logic [15:0] rnd_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic test_directed();
        // extremes on load and assign, ties, empty clusters, unused function
        send_request(FUNC_LOAD, 4'd0, 16'h8000, 16'h8000);
        send_request(FUNC_LOAD, 4'd1, 16'h7fff, 16'h7fff);
        send_request(FUNC_LOAD, 4'd2, 16'h0000, 16'h0000);
        send_request(FUNC_LOAD, 4'd3, 16'h0000, 16'h0000);
        send_request(FUNC_LOAD, 4'd15, 16'h1234, 16'hedcb);
        send_request(FUNC_ASSIGN, 4'd15, 16'h8000, 16'h7fff);
        send_request(FUNC_ASSIGN, 4'd0, 16'h7fff, 16'h7fff);
        send_request(FUNC_ASSIGN, 4'd0, 16'h0000, 16'h0000);
        send_request(FUNC_ASSIGN, 4'd0, 16'h8000, 16'h8000);
        send_request(FUNC_UNUSED, 4'd9, 16'hffff, 16'hffff);
        send_request(FUNC_ASSIGN, 4'd0, 16'hffff, 16'h0001);
        send_request(FUNC_UPDATE, 4'd5, 16'hffff, 16'hffff);
        send_request(FUNC_UPDATE, 4'd0, 16'h0000, 16'h0000);
        send_request(FUNC_ASSIGN, 4'd0, 16'h0003, 16'hfffd);
        send_request(FUNC_ASSIGN, 4'd0, 16'h0004, 16'hfffd);
        send_request(FUNC_UPDATE, 4'd0, 16'h0000, 16'h0000);
    endtask

    task automatic test_random_epochs(int epochs, logic [4:0] act);
        int n, pts, fsel;
        write_active(act);
        n = (act < 1) ? 1 : (act > NCL ? NCL : act);
        for (int e = 0; e < epochs; e++) begin
            for (int k = 0; k < n; k++)
                if ($urandom_range(0, 3) != 0)
                    send_request(FUNC_LOAD, 4'(k), rnd_coord(), rnd_coord());
            pts = $urandom_range(4, 30);
            for (int p = 0; p < pts; p++) begin
                fsel = $urandom_range(0, 99);
                if (fsel < 88)
                    send_request(FUNC_ASSIGN, 4'($urandom), rnd_coord(), rnd_coord());
                else if (fsel < 94)
                    send_request(FUNC_LOAD, 4'($urandom), rnd_coord(), rnd_coord());
                else if (fsel < 97)
                    send_request(FUNC_UNUSED, 4'($urandom), rnd_coord(), rnd_coord());
                else
                    send_request(FUNC_UPDATE, 4'($urandom), rnd_coord(), rnd_coord());
            end
            send_request(FUNC_UPDATE, 4'($urandom), rnd_coord(), rnd_coord());
            // a second update with no assigns in between always settles unmoved
            if ($urandom_range(0, 1))
                send_request(FUNC_UPDATE, 4'd0, 16'd0, 16'd0);
        end
    endtask

    task automatic test_output_stall();
        wait_idle();
        stall_test = 1;
        for (int i = 0; i < 12; i++)
            send_request(FUNC_ASSIGN, 4'($urandom), rnd_coord(), rnd_coord(), 0);
        stall_test = 0;
    endtask

    initial begin
        for (int k = 0; k < NCL; k++) begin
            cen_x[k] = 0; cen_y[k] = 0;
            acc_x[k] = 0; acc_y[k] = 0; members[k] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_output_stall();
        test_random_epochs(10, 5'd16);
        test_random_epochs(16, 5'd1);
        test_random_epochs(12, 5'd0);
        test_random_epochs(10, 5'd31);
        test_random_epochs(12, 5'd2);
        test_random_epochs(12, 5'd7);
        test_random_epochs(10, 5'd4);
        wait_idle();
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
